@@ rtl/core/kcc_pkg.sv @@
// Shared types and constants for the keypad calculator controller.
// Used by kcc_iter_unit and keypad_calculator_controller.
`timescale 1ns / 1ps

package kcc_pkg;

	localparam int DATA_W = 32;
	localparam int STEP_W = $clog2(DATA_W);

	localparam logic [7:0] KEY_0     = 8'h30;
	localparam logic [7:0] KEY_9     = 8'h39;
	localparam logic [7:0] KEY_ADD   = 8'h2B;
	localparam logic [7:0] KEY_SUB   = 8'h2D;
	localparam logic [7:0] KEY_MUL   = 8'h2A;
	localparam logic [7:0] KEY_DIV   = 8'h2F;
	localparam logic [7:0] KEY_EQ    = 8'h3D;
	localparam logic [7:0] KEY_CLEAR = 8'h43;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	// request to the shared multiply/divide unit
	typedef struct packed {
		logic start;
		logic op_div;
	} iter_req_t;

endpackage

@@ rtl/core/kcc_iter_unit.sv @@
// Shared iterative unit: 32-step shift-add multiply and restoring signed divide.
// One adder serves both operations. Depends on kcc_pkg.
`timescale 1ns / 1ps

module kcc_iter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kcc_pkg::iter_req_t            req,
	input  logic [kcc_pkg::DATA_W-1:0]    opa,
	input  logic [kcc_pkg::DATA_W-1:0]    opb,
	output logic                          busy,
	output logic [kcc_pkg::DATA_W-1:0]    result
);
	import kcc_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

	logic              busy_q;
	logic              div_q;
	logic              neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DATA_W-1:0] acc_q;   // product, or partial remainder
	logic [DATA_W-1:0] a_q;     // multiplicand, or dividend/quotient
	logic [DATA_W-1:0] b_q;     // multiplier, or divisor magnitude

	logic [DATA_W-1:0] mag_a, mag_b;
	logic [DATA_W:0]   rem_shift;
	logic [DATA_W:0]   add_x, add_y;
	logic [DATA_W+1:0] add_sum;
	logic              no_borrow;

	assign mag_a = opa[DATA_W-1] ? (~opa + DATA_W'(1)) : opa;
	assign mag_b = opb[DATA_W-1] ? (~opb + DATA_W'(1)) : opb;

	assign rem_shift = {acc_q, a_q[DATA_W-1]};

	// shared adder: acc + multiplicand, or remainder - divisor
	always_comb begin
		if (div_q) begin
			add_x = rem_shift;
			add_y = ~{1'b0, b_q};
		end else begin
			add_x = {1'b0, acc_q};
			add_y = {1'b0, a_q};
		end
	end
	assign add_sum   = {1'b0, add_x} + {1'b0, add_y} + {{(DATA_W+1){1'b0}}, div_q};
	assign no_borrow = add_sum[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.op_div;
			neg_q <= opa[DATA_W-1] ^ opb[DATA_W-1];
			acc_q <= '0;
			a_q   <= req.op_div ? mag_a : opa;
			b_q   <= req.op_div ? mag_b : opb;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= no_borrow ? add_sum[DATA_W-1:0] : rem_shift[DATA_W-1:0];
				a_q   <= {a_q[DATA_W-2:0], no_borrow};
			end else begin
				if (b_q[0]) begin
					acc_q <= add_sum[DATA_W-1:0];
				end
				a_q <= {a_q[DATA_W-2:0], 1'b0};
				b_q <= {1'b0, b_q[DATA_W-1:1]};
			end
		end
	end

	assign busy   = busy_q;
	assign result = div_q ? (neg_q ? (~a_q + DATA_W'(1)) : a_q) : acc_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("iter unit started while busy");
	a_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == LAST_STEP) |=> !busy_q)
		else $error("iter unit ran past last step");
	a_count_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> (busy_q && cnt_q == '0))
		else $error("iter unit did not start at step zero");
`endif

endmodule

@@ rtl/core/keypad_calculator_controller.sv @@
// Keypad four-function calculator controller: key decode, operand state and
// result register around the shared multiply/divide unit. Depends on kcc_pkg, kcc_iter_unit.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid / in_stall / key_code): one ASCII key code per word.
//  Output channel (out_valid / out_stall / result fields): exactly one result
//  word per key word, in order.
//  Digits, operators, 'C', other keys and '=' with +, - or no operator pending
//  finish at acceptance: the accepting edge loads the result word into the
//  output register, and keys can follow back to back while out_stall is low.
//  '=' with '*' or '/' pending runs the shared unit for 32 steps: the result
//  word is loaded once the unit is done and the output is free, and the next
//  key can go in once that word is loaded.
//  The 32 steps are counted by the loop in kcc_iter_unit.
//  Division by zero is caught at acceptance and never starts the shared unit.
//  One key is processed at a time; in_stall stays high while the unit runs.
//  A new key is taken while a result word is leaving (out_valid && !out_stall).
//  Receiver stall: the result word holds in the output register and in_stall
//  rises until it is taken.
//  Reset (arst_n low): operands, last result and pending operator clear to
//  zero/none, no result word is pending.
//  Arithmetic is 32-bit two's complement and wraps; division truncates toward zero.
module keypad_calculator_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        key_code,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              echo_valid,
	output logic [7:0]                        echo_char,
	output logic                              number_valid,
	output logic signed [kcc_pkg::DATA_W-1:0] number_value,
	output logic                              div_zero_error,
	output logic                              clear_display
);
	import kcc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_CALC = 2'b10
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] first_q, second_q, last_q;
	op_t               pend_q;
	logic              second_entry_q;

	logic              out_valid_q;
	logic              echo_valid_q, number_valid_q, div_err_q, clear_q;
	logic [7:0]        echo_char_q;
	logic [DATA_W-1:0] number_q;

	iter_req_t         req;
	logic              unit_busy;
	logic [DATA_W-1:0] unit_result;

	logic              out_free, accept, calc_done;
	logic              is_digit, is_op, is_eq, is_clear;
	logic [3:0]        digit;
	logic [DATA_W-1:0] entry_val, entry_next, eq_result;
	op_t               key_op;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign calc_done = (state_q == S_CALC) && !unit_busy && out_free;

	// key decode
	assign is_digit = (key_code >= KEY_0) && (key_code <= KEY_9);
	assign is_op    = (key_code == KEY_ADD) || (key_code == KEY_SUB) ||
	                  (key_code == KEY_MUL) || (key_code == KEY_DIV);
	assign is_eq    = (key_code == KEY_EQ);
	assign is_clear = (key_code == KEY_CLEAR);
	assign digit    = 4'(key_code - KEY_0);

	always_comb begin
		unique case (key_code)
			KEY_ADD: key_op = OP_ADD;
			KEY_SUB: key_op = OP_SUB;
			KEY_MUL: key_op = OP_MUL;
			KEY_DIV: key_op = OP_DIV;
			default: key_op = OP_NONE;
		endcase
	end

	// operand entry: x*10 + d as two shifts and two adds
	assign entry_val  = second_entry_q ? second_q : first_q;
	assign entry_next = {entry_val[DATA_W-4:0], 3'b000} + {entry_val[DATA_W-2:0], 1'b0} +
	                    {{(DATA_W-4){1'b0}}, digit};

	// results of '=' that need no shared unit
	always_comb begin
		case (pend_q)
			OP_ADD:  eq_result = first_q + second_q;
			OP_SUB:  eq_result = first_q - second_q;
			default: eq_result = last_q;
		endcase
	end

	// multiply and divide go to the shared unit; divide by zero never starts it
	assign req.start  = accept && is_eq &&
	                    ((pend_q == OP_MUL) || ((pend_q == OP_DIV) && (second_q != '0)));
	assign req.op_div = (pend_q == OP_DIV);

	kcc_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (first_q),
		.opb    (second_q),
		.busy   (unit_busy),
		.result (unit_result)
	);

	// sequencer and calculator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_q        <= '0;
			second_q       <= '0;
			last_q         <= '0;
			pend_q         <= OP_NONE;
			second_entry_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_digit) begin
							if (second_entry_q) begin
								second_q <= entry_next;
							end else begin
								first_q <= entry_next;
							end
						end else if (is_op) begin
							if (pend_q == OP_NONE) begin
								pend_q         <= key_op;
								second_entry_q <= 1'b1;
							end
						end else if (is_eq) begin
							if (req.start) begin
								state_q <= S_CALC;
							end else if ((pend_q == OP_DIV) || is_clear) begin
								// division by zero: back to reset state
								first_q        <= '0;
								second_q       <= '0;
								last_q         <= '0;
								pend_q         <= OP_NONE;
								second_entry_q <= 1'b0;
							end else begin
								last_q         <= eq_result;
								first_q        <= eq_result;
								second_q       <= '0;
								pend_q         <= OP_NONE;
								second_entry_q <= 1'b0;
							end
						end else if (is_clear) begin
							first_q        <= '0;
							second_q       <= '0;
							last_q         <= '0;
							pend_q         <= OP_NONE;
							second_entry_q <= 1'b0;
						end
					end
				end
				S_CALC: begin
					if (calc_done) begin
						last_q         <= unit_result;
						first_q        <= unit_result;
						second_q       <= '0;
						pend_q         <= OP_NONE;
						second_entry_q <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && !req.start) begin
			out_valid_q <= 1'b1;
		end else if (calc_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req.start) begin
			echo_valid_q   <= 1'b0;
			echo_char_q    <= 8'h00;
			number_valid_q <= 1'b0;
			number_q       <= '0;
			div_err_q      <= 1'b0;
			clear_q        <= 1'b0;
			if (is_digit) begin
				echo_valid_q <= 1'b1;
				echo_char_q  <= key_code;
			end else if (is_op) begin
				if (pend_q == OP_NONE) begin
					echo_valid_q <= 1'b1;
					echo_char_q  <= key_code;
				end
			end else if (is_eq) begin
				echo_valid_q <= 1'b1;
				echo_char_q  <= KEY_EQ;
				if (pend_q == OP_DIV) begin
					div_err_q <= 1'b1;
					clear_q   <= 1'b1;
				end else begin
					number_valid_q <= 1'b1;
					number_q       <= eq_result;
				end
			end else if (is_clear) begin
				clear_q <= 1'b1;
			end
		end else if (calc_done) begin
			echo_valid_q   <= 1'b1;
			echo_char_q    <= KEY_EQ;
			number_valid_q <= 1'b1;
			number_q       <= unit_result;
			div_err_q      <= 1'b0;
			clear_q        <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign echo_valid     = echo_valid_q;
	assign echo_char      = echo_char_q;
	assign number_valid   = number_valid_q;
	assign number_value   = number_q;
	assign div_zero_error = div_err_q;
	assign clear_display  = clear_q;

`ifndef SYNTHESIS
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
	a_calc_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CALC) |-> in_stall)
		else $error("key accepted during calculation");
	a_key_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_valid || state_q == S_CALC))
		else $error("accepted key produced no result word");
	a_unit_only_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		unit_busy |-> (state_q == S_CALC))
		else $error("shared unit busy outside calculation");
	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_zero_error) |-> (clear_display && echo_valid && !number_valid))
		else $error("divide error word malformed");
	a_error_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_eq && pend_q == OP_DIV && second_q == '0) |=>
		(pend_q == OP_NONE && first_q == '0 && last_q == '0))
		else $error("divide by zero did not clear state");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for keypad_calculator_controller: key words in, result words out.
// Depends on kcc_pkg and the controller RTL; predicts each result word from its own calculator state.
`timescale 1ns / 1ps

module tb;
	import kcc_pkg::*;

	// One result word, as the block presents it on its output fields.
	typedef struct packed {
		logic                     echo_valid;
		logic [7:0]               echo_char;
		logic                     number_valid;
		logic signed [DATA_W-1:0] number_value;
		logic                     div_zero_error;
		logic                     clear_display;
	} calc_word_t;

	// Predicted word plus the key that caused it, for readable mismatch lines.
	typedef struct packed {
		logic [7:0] key;
		calc_word_t word;
	} expected_word_t;

	// Key word waiting to be sent; wait_idle holds it back until nothing is outstanding.
	typedef struct packed {
		logic [7:0] key;
		logic       wait_idle;
	} pending_key_t;

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic [7:0]               key_code       = 8'h00;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic                     echo_valid;
	logic [7:0]               echo_char;
	logic                     number_valid;
	logic signed [DATA_W-1:0] number_value;
	logic                     div_zero_error;
	logic                     clear_display;

	pending_key_t   key_q[$];     // keys still to be sent
	expected_word_t result_q[$];  // predicted words not yet seen at the output
	int             mismatch_count = 0;
	int             keys_queued    = 0;

	// Calculator state as the predictor sees it.
	logic [DATA_W-1:0] calc_first;
	logic [DATA_W-1:0] calc_second;
	logic [DATA_W-1:0] calc_last;
	op_t               calc_op;
	logic              calc_on_second;

	keypad_calculator_controller u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.key_code       (key_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.echo_valid     (echo_valid),
		.echo_char      (echo_char),
		.number_valid   (number_valid),
		.number_value   (number_value),
		.div_zero_error (div_zero_error),
		.clear_display  (clear_display)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void calc_clear();
		calc_first     = '0;
		calc_second    = '0;
		calc_last      = '0;
		calc_op        = OP_NONE;
		calc_on_second = 1'b0;
	endfunction

	// Signed divide that truncates toward zero, done on magnitudes so that the
	// most negative value over minus one simply wraps back to itself.
	function automatic logic [DATA_W-1:0] quotient_trunc(input logic [DATA_W-1:0] num,
							     input logic [DATA_W-1:0] den);
		logic [DATA_W-1:0] mag_n;
		logic [DATA_W-1:0] mag_d;
		logic [DATA_W-1:0] q;
		mag_n = num[DATA_W-1] ? -num : num;
		mag_d = den[DATA_W-1] ? -den : den;
		q     = mag_n / mag_d;
		return (num[DATA_W-1] != den[DATA_W-1]) ? -q : q;
	endfunction

	// Apply one key to the calculator state and return the word it should produce.
	function automatic calc_word_t press_key(input logic [7:0] key);
		calc_word_t        w;
		logic [DATA_W-1:0] digit;
		logic [DATA_W-1:0] r;
		logic              div_err;
		w       = '0;
		div_err = 1'b0;
		if (key >= KEY_0 && key <= KEY_9) begin
			// digits always echo and extend the operand being typed, wrapping at 32 bits
			digit        = DATA_W'(key - KEY_0);
			w.echo_valid = 1'b1;
			w.echo_char  = key;
			if (!calc_on_second)
				calc_first = calc_first * 10 + digit;
			else
				calc_second = calc_second * 10 + digit;
		end else if (key == KEY_ADD || key == KEY_SUB || key == KEY_MUL || key == KEY_DIV) begin
			// a second operator while one is pending is dropped silently
			if (calc_op == OP_NONE) begin
				w.echo_valid   = 1'b1;
				w.echo_char    = key;
				calc_on_second = 1'b1;
				case (key)
					KEY_ADD: calc_op = OP_ADD;
					KEY_SUB: calc_op = OP_SUB;
					KEY_MUL: calc_op = OP_MUL;
					default: calc_op = OP_DIV;
				endcase
			end
		end else if (key == KEY_EQ) begin
			w.echo_valid = 1'b1;
			w.echo_char  = KEY_EQ;
			r            = calc_last;  // no operator: show the previous result again
			case (calc_op)
				OP_ADD: r = calc_first + calc_second;
				OP_SUB: r = calc_first - calc_second;
				OP_MUL: r = calc_first * calc_second;
				OP_DIV: begin
					if (calc_second != '0)
						r = quotient_trunc(calc_first, calc_second);
					else
						div_err = 1'b1;
				end
				default: ;
			endcase
			if (div_err) begin
				w.div_zero_error = 1'b1;
				w.clear_display  = 1'b1;
				calc_clear();
			end else begin
				w.number_valid = 1'b1;
				w.number_value = r;
				calc_last      = r;
				calc_first     = r;
				calc_second    = '0;
				calc_op        = OP_NONE;
				calc_on_second = 1'b0;
			end
		end else if (key == KEY_CLEAR) begin
			w.clear_display = 1'b1;
			calc_clear();
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] key,
				       input logic [31:0] got, input logic [31:0] want);
		mismatch_count++;
		$display("MISMATCH %0t ns key 0x%02h: %s got 0x%08h expected 0x%08h",
			 $time, key, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Stimulus build
	// ------------------------------------------------------------------

	// Every 300th key waits for the block to drain completely before it goes.
	task automatic add_key(input logic [7:0] key);
		pending_key_t p;
		p.key       = key;
		p.wait_idle = (keys_queued % 300 == 299);
		key_q.push_back(p);
		keys_queued++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_key(s[i]);
	endtask

	// Mostly short operands, now and then long enough to wrap 32 bits.
	task automatic add_digits(input bit allow_empty);
		int n;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0 && allow_empty)
			n = 0;
		else if (pick < 7)
			n = $urandom_range(1, 4);
		else
			n = $urandom_range(5, 12);
		for (int i = 0; i < n; i++)
			add_key(KEY_0 + 8'($urandom_range(0, 9)));
	endtask

	function automatic logic [7:0] any_operator();
		case ($urandom_range(0, 3))
			0:       return KEY_ADD;
			1:       return KEY_SUB;
			2:       return KEY_MUL;
			default: return KEY_DIV;
		endcase
	endfunction

	initial begin
		int counted;
		int pick;
		int n;
		logic [7:0] op_key;

		calc_clear();

		// Directed: key code extremes, '=' with nothing pending, an operator
		// pressed while one is pending, each operation, a negative quotient that
		// must truncate toward zero, divide by zero, then 'C'.
		add_key(8'h00);
		add_key(8'hFF);
		add_text("=");
		add_text("9+-4=");   // 13, the '-' is dropped
		add_text("-20=");    // -7
		add_text("/2=");     // -3
		add_text("*3=");     // -9
		add_text("/0=");     // error, full clear
		add_text("C");

		// Random part: mostly well-formed expressions with random operands,
		// plus extreme operands, clears and junk keys.
		counted = 0;
		while (counted < 1250) begin
			n    = keys_queued;
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				if ($urandom_range(0, 9) == 0)
					add_key(KEY_CLEAR);
				// sometimes chain straight off the last result
				if ($urandom_range(0, 9) < 7)
					add_digits(1'b1);
				op_key = any_operator();
				add_key(op_key);
				if ($urandom_range(0, 6) == 0)
					add_key(any_operator());
				// a lone zero or empty operand provokes divide by zero
				if (op_key == KEY_DIV && $urandom_range(0, 7) == 0)
					add_key(KEY_0);
				else
					add_digits(1'b1);
				add_key(KEY_EQ);
				if ($urandom_range(0, 6) == 0)
					add_key(KEY_EQ);
				counted += keys_queued - n;
			end else if (pick < 72) begin
				// cleared first so the operands are exactly as typed
				case ($urandom_range(0, 4))
					0: add_text("C2147483648/4294967295=");  // most negative / -1
					1: add_text("C4294967295*4294967295=");
					2: add_text("C2147483647+1=");
					3: add_text("C0-2147483648/7=");
					default: add_text("C4294967295/2=");
				endcase
				counted += keys_queued - n;
			end else if (pick < 78) begin
				add_key(KEY_CLEAR);
				counted++;
			end else if (pick < 84) begin
				add_key(KEY_EQ);
				counted++;
			end else begin
				// junk keys: any byte, which may also be a digit, operator, '=' or 'C'
				repeat ($urandom_range(1, 3))
					add_key(8'($urandom_range(0, 255)));
				counted += keys_queued - n;
			end
		end

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for everything sent and every word back, then let the block settle.
		forever begin
			@(posedge clk);
			if (key_q.size() == 0 && !in_valid && result_q.size() == 0)
				break;
		end
		repeat (50) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: bursts of key words with random gaps
	// ------------------------------------------------------------------

	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		expected_word_t e;
		if (!arst_n) begin
			in_valid <= 1'b0;
			key_code <= 8'h00;
		end else begin
			// word taken at this edge: predict its result now
			if (in_valid && !in_stall) begin
				e.key  = key_code;
				e.word = press_key(key_code);
				result_q.push_back(e);
			end
			// a stalled word holds; otherwise decide what goes next
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (key_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (key_q[0].wait_idle && result_q.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					key_code <= key_q[0].key;
					void'(key_q.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result word, and stalls in stretches of varying density
	// ------------------------------------------------------------------

	int stretch_left = 0;
	int stall_pct    = 0;

	always @(posedge clk or negedge arst_n) begin
		expected_word_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected word", 8'h00, 32'(echo_char), 32'h0);
				end else begin
					e = result_q.pop_front();
					if (echo_valid !== e.word.echo_valid)
						report_mismatch("echo_valid", e.key, 32'(echo_valid),
								32'(e.word.echo_valid));
					if (echo_char !== e.word.echo_char)
						report_mismatch("echo_char", e.key, 32'(echo_char),
								32'(e.word.echo_char));
					if (number_valid !== e.word.number_valid)
						report_mismatch("number_valid", e.key, 32'(number_valid),
								32'(e.word.number_valid));
					if (number_value !== e.word.number_value)
						report_mismatch("number_value", e.key, number_value,
								e.word.number_value);
					if (div_zero_error !== e.word.div_zero_error)
						report_mismatch("div_zero_error", e.key, 32'(div_zero_error),
								32'(e.word.div_zero_error));
					if (clear_display !== e.word.clear_display)
						report_mismatch("clear_display", e.key, 32'(clear_display),
								32'(e.word.clear_display));
				end
			end
			// stretches with no stall at all, light, medium and heavy stalling
			if (stretch_left <= 0) begin
				stretch_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 50;
					default: stall_pct = 80;
				endcase
			end
			stretch_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
